// ----- design/pkeg_pkg.sv -----
// Shared types and constants for the pointer and key event generator.
// No dependencies; every design file refers to this package by scoped names.
package pkeg_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int BTN_W       = 3;   // width of the button level field
  localparam int BTN_USED    = (NUM_BUTTONS < BTN_W) ? NUM_BUTTONS : BTN_W;
  localparam int BIDX_W      = $clog2(BTN_W);
  localparam int COORD_W     = 12;
  localparam int SIZE_W      = 13;
  localparam int REL_W       = 9;
  localparam int SUM_W       = COORD_W + 2;
  localparam int KIND_W      = 3;
  localparam int BNUM_W      = 2;
  localparam int CODE_W      = 8;

  localparam logic [SIZE_W-1:0] SIZE_MAX     = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] RESET_WIDTH  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT = SIZE_W'(480);

  // Event slots of one job, emitted lowest first.
  localparam int SLOT_MOVE = 0;
  localparam int SLOT_KEY  = BTN_W + 1;
  localparam int SLOT_N    = BTN_W + 2;
  localparam int SEL_W     = $clog2(SLOT_N);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_index_t;

  typedef enum logic [KIND_W-1:0] {
    EV_MOVE     = 3'd0,
    EV_BTN_DOWN = 3'd1,
    EV_BTN_UP   = 3'd2,
    EV_KEY_DOWN = 3'd3,
    EV_KEY_UP   = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [BTN_W-1:0]   levels;
    logic [SLOT_N-1:0]  slots;
    logic               key_release;
    logic [CODE_W-1:0]  key_code;
  } job_t;

  // Written sizes: zero reads as one, anything above the maximum saturates.
  function automatic logic [SIZE_W-1:0] fix_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W-1:0] s;
    s = v;
    if (s == '0) s = SIZE_W'(1);
    if (s > SIZE_MAX) s = SIZE_MAX;
    return s;
  endfunction

endpackage

// ----- design/pointer_and_key_event_generator_top.sv -----
// Pointer and key event generator, top level.
// An item's events pass through the job queue, the back end's job register
// and its output register. Throughput: one event per cycle from the back end
// when out_ready allows; items carry up to 5 events, empty ones are not queued.
// Input stalls only when the 2-entry job queue is full.
// Reset: synchronous; 640x480 screen, pointer centered, buttons released.
module pointer_and_key_event_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           has_motion,
  input  logic                           has_key,
  input  logic signed [pkeg_pkg::REL_W-1:0] rel_x,
  input  logic signed [pkeg_pkg::REL_W-1:0] rel_y,
  input  logic [pkeg_pkg::BTN_W-1:0]     button_levels,
  input  logic                           key_release,
  input  logic [pkeg_pkg::CODE_W-1:0]    key_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [pkeg_pkg::SIZE_W-1:0]    cfg_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [pkeg_pkg::KIND_W-1:0]    event_kind,
  output logic [pkeg_pkg::COORD_W-1:0]   pos_x,
  output logic [pkeg_pkg::COORD_W-1:0]   pos_y,
  output logic [pkeg_pkg::BNUM_W-1:0]    button_number,
  output logic [pkeg_pkg::BTN_W-1:0]     button_mask,
  output logic [pkeg_pkg::CODE_W-1:0]    scan_out,
  output logic                           last
);

  logic           q_push, q_full, q_pop, q_valid;
  pkeg_pkg::job_t q_job, q_head;

  pkeg_front u_front (
    .clk, .rst,
    .in_valid, .in_ready,
    .has_motion, .has_key, .rel_x, .rel_y, .button_levels, .key_release, .key_code,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_push, .q_job, .q_full
  );

  pkeg_queue u_queue (
    .clk, .rst,
    .push(q_push), .push_job(q_job), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  pkeg_back u_back (
    .clk, .rst,
    .q_valid, .q_head, .q_pop,
    .out_valid, .out_ready,
    .event_kind, .pos_x, .pos_y, .button_number, .button_mask, .scan_out, .last
  );

endmodule

// ----- design/pkeg_front.sv -----
// Front end: takes input transactions and config writes, tracks pointer and
// button state, and pushes one job per non-empty item. Uses pkeg_pkg.
module pkeg_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           has_motion,
  input  logic                           has_key,
  input  logic signed [pkeg_pkg::REL_W-1:0] rel_x,
  input  logic signed [pkeg_pkg::REL_W-1:0] rel_y,
  input  logic [pkeg_pkg::BTN_W-1:0]     button_levels,
  input  logic                           key_release,
  input  logic [pkeg_pkg::CODE_W-1:0]    key_code,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [0:0]                     cfg_index,
  input  logic [pkeg_pkg::SIZE_W-1:0]    cfg_data,
  output logic                           q_push,
  output pkeg_pkg::job_t                 q_job,
  input  logic                           q_full
);

  logic [pkeg_pkg::SIZE_W-1:0]  screen_width, screen_width_next;
  logic [pkeg_pkg::SIZE_W-1:0]  screen_height, screen_height_next;
  logic [pkeg_pkg::COORD_W-1:0] pointer_x, pointer_x_next;
  logic [pkeg_pkg::COORD_W-1:0] pointer_y, pointer_y_next;
  logic [pkeg_pkg::BTN_W-1:0]   button_state, button_state_next;

  logic                          accept;
  logic                          cfg_write;
  logic [pkeg_pkg::SIZE_W-1:0]   new_size;
  logic [pkeg_pkg::BTN_W-1:0]    used_mask;
  logic [pkeg_pkg::BTN_W-1:0]    levels;
  logic [pkeg_pkg::BTN_W-1:0]    changed;
  logic signed [pkeg_pkg::SUM_W-1:0] sum_x, sum_y;
  logic [pkeg_pkg::COORD_W-1:0]  hi_x, hi_y, clamp_x, clamp_y;
  logic                          moved;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign cfg_write = cfg_valid && cfg_ready;
  assign new_size  = pkeg_pkg::fix_size(cfg_data);

  always_comb begin
    used_mask = '0;
    for (int i = 0; i < pkeg_pkg::BTN_USED; i++) used_mask[i] = 1'b1;
  end

  assign levels  = button_levels & used_mask;
  assign changed = levels ^ button_state;

  assign hi_x  = pkeg_pkg::COORD_W'(screen_width - pkeg_pkg::SIZE_W'(1));
  assign hi_y  = pkeg_pkg::COORD_W'(screen_height - pkeg_pkg::SIZE_W'(1));
  assign sum_x = $signed({2'b00, pointer_x})
               + $signed({{(pkeg_pkg::SUM_W-pkeg_pkg::REL_W){rel_x[pkeg_pkg::REL_W-1]}}, rel_x});
  // positive rel_y is upward, screen Y grows downward
  assign sum_y = $signed({2'b00, pointer_y})
               - $signed({{(pkeg_pkg::SUM_W-pkeg_pkg::REL_W){rel_y[pkeg_pkg::REL_W-1]}}, rel_y});

  always_comb begin
    priority if (sum_x[pkeg_pkg::SUM_W-1]) clamp_x = '0;
    else if (sum_x[pkeg_pkg::SUM_W-2:0] > {1'b0, hi_x}) clamp_x = hi_x;
    else clamp_x = sum_x[pkeg_pkg::COORD_W-1:0];
    priority if (sum_y[pkeg_pkg::SUM_W-1]) clamp_y = '0;
    else if (sum_y[pkeg_pkg::SUM_W-2:0] > {1'b0, hi_y}) clamp_y = hi_y;
    else clamp_y = sum_y[pkeg_pkg::COORD_W-1:0];
  end

  assign moved = (clamp_x != pointer_x) || (clamp_y != pointer_y);

  always_comb begin
    screen_width_next  = screen_width;
    screen_height_next = screen_height;
    pointer_x_next     = pointer_x;
    pointer_y_next     = pointer_y;
    button_state_next  = button_state;
    if (cfg_write) begin
      unique case (cfg_index)
        pkeg_pkg::REG_WIDTH:  screen_width_next  = new_size;
        pkeg_pkg::REG_HEIGHT: screen_height_next = new_size;
        default: ;
      endcase
      pointer_x_next = pkeg_pkg::COORD_W'(screen_width_next >> 1);
      pointer_y_next = pkeg_pkg::COORD_W'(screen_height_next >> 1);
    end else if (accept && has_motion) begin
      pointer_x_next    = clamp_x;
      pointer_y_next    = clamp_y;
      button_state_next = levels;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= pkeg_pkg::RESET_WIDTH;
      screen_height <= pkeg_pkg::RESET_HEIGHT;
      pointer_x     <= pkeg_pkg::COORD_W'(pkeg_pkg::RESET_WIDTH >> 1);
      pointer_y     <= pkeg_pkg::COORD_W'(pkeg_pkg::RESET_HEIGHT >> 1);
      button_state  <= '0;
    end else begin
      screen_width  <= screen_width_next;
      screen_height <= screen_height_next;
      pointer_x     <= pointer_x_next;
      pointer_y     <= pointer_y_next;
      button_state  <= button_state_next;
    end
  end

  // Job classification: which events this item causes.
  always_comb begin
    q_job             = '0;
    q_job.pos_x       = has_motion ? clamp_x : pointer_x;
    q_job.pos_y       = has_motion ? clamp_y : pointer_y;
    q_job.levels      = levels;
    q_job.key_release = key_release;
    q_job.key_code    = key_code;
    q_job.slots[pkeg_pkg::SLOT_MOVE] = has_motion && moved;
    for (int i = 0; i < pkeg_pkg::BTN_W; i++) begin
      q_job.slots[i + 1] = has_motion && changed[i];
    end
    q_job.slots[pkeg_pkg::SLOT_KEY] = has_key;
  end

  assign q_push = accept && (q_job.slots != '0);

endmodule

// ----- design/pkeg_queue.sv -----
// Short job queue between front and back end, built from registers.
// Uses pkeg_pkg for the job type and depth.
module pkeg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  pkeg_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output pkeg_pkg::job_t head
);

  pkeg_pkg::job_t               entries [pkeg_pkg::QUEUE_DEPTH];
  logic [pkeg_pkg::QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [pkeg_pkg::QCNT_W-1:0]  count;
  logic                         do_push, do_pop;

  assign full    = (count == pkeg_pkg::QCNT_W'(pkeg_pkg::QUEUE_DEPTH));
  assign valid   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  function automatic logic [pkeg_pkg::QPTR_W-1:0] bump(input logic [pkeg_pkg::QPTR_W-1:0] p);
    return (p == pkeg_pkg::QPTR_W'(pkeg_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= bump(wr_ptr);
      if (do_pop)  rd_ptr <= bump(rd_ptr);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_job;
  end

endmodule

// ----- design/pkeg_back.sv -----
// Back end: walks the event slots of one job, one event per cycle while the
// output is not stalled, into an output register. Uses pkeg_pkg.
module pkeg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  input  pkeg_pkg::job_t               q_head,
  output logic                         q_pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [pkeg_pkg::KIND_W-1:0]  event_kind,
  output logic [pkeg_pkg::COORD_W-1:0] pos_x,
  output logic [pkeg_pkg::COORD_W-1:0] pos_y,
  output logic [pkeg_pkg::BNUM_W-1:0]  button_number,
  output logic [pkeg_pkg::BTN_W-1:0]   button_mask,
  output logic [pkeg_pkg::CODE_W-1:0]  scan_out,
  output logic                         last
);

  pkeg_pkg::job_t               job;
  logic                         job_valid;
  logic [pkeg_pkg::SLOT_N-1:0]  rem, rem_next;
  logic [pkeg_pkg::SEL_W-1:0]   sel;
  logic                         advance, emit, job_done;
  logic                         ev_last;
  pkeg_pkg::event_kind_t        ev_kind;
  logic [pkeg_pkg::BNUM_W-1:0]  ev_bnum;
  logic [pkeg_pkg::BTN_W-1:0]   ev_mask;
  logic [pkeg_pkg::CODE_W-1:0]  ev_scan;

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = pkeg_pkg::SLOT_N - 1; i >= 0; i--) begin
      if (rem[i]) sel = pkeg_pkg::SEL_W'(i);
    end
  end

  always_comb begin
    rem_next      = rem;
    rem_next[sel] = 1'b0;
  end

  assign ev_last  = (rem_next == '0);
  assign advance  = !out_valid || out_ready;
  assign emit     = advance && job_valid;
  assign job_done = emit && ev_last;
  assign q_pop    = q_valid && (!job_valid || job_done);

  always_comb begin
    ev_bnum = '0;
    ev_mask = job.levels;
    ev_scan = '0;
    priority if (sel == pkeg_pkg::SEL_W'(pkeg_pkg::SLOT_MOVE)) begin
      ev_kind = pkeg_pkg::EV_MOVE;
    end else if (sel == pkeg_pkg::SEL_W'(pkeg_pkg::SLOT_KEY)) begin
      ev_kind = job.key_release ? pkeg_pkg::EV_KEY_UP : pkeg_pkg::EV_KEY_DOWN;
      ev_mask = '0;
      ev_scan = job.key_code;
    end else begin
      // button slot i+1 carries button number i+1
      ev_kind = job.levels[pkeg_pkg::BIDX_W'(sel - 1'b1)] ? pkeg_pkg::EV_BTN_DOWN
                                                         : pkeg_pkg::EV_BTN_UP;
      ev_bnum = pkeg_pkg::BNUM_W'(sel);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        job_valid <= 1'b1;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
      if (advance) out_valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job <= q_head;
      rem <= q_head.slots;
    end else if (emit) begin
      rem <= rem_next;
    end
    if (emit) begin
      event_kind    <= ev_kind;
      pos_x         <= job.pos_x;
      pos_y         <= job.pos_y;
      button_number <= ev_bnum;
      button_mask   <= ev_mask;
      scan_out      <= ev_scan;
      last          <= ev_last;
    end
  end

endmodule

// ----- verif/pointer_and_key_event_generator_top_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pointer_and_key_event_generator_top.
// Depends on design/pkeg_pkg.sv and the top level; drives reports and screen
// sizes, predicts the event stream and compares it at the output handshake.
module pointer_and_key_event_generator_top_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORTS_PER_PHASE = 43;
  localparam logic [pkeg_pkg::BTN_W-1:0] BTN_KEEP =
    pkeg_pkg::BTN_W'((1 << pkeg_pkg::BTN_USED) - 1);

  typedef struct {
    logic                              has_motion;
    logic                              has_key;
    logic signed [pkeg_pkg::REL_W-1:0] rel_x;
    logic signed [pkeg_pkg::REL_W-1:0] rel_y;
    logic [pkeg_pkg::BTN_W-1:0]        button_levels;
    logic                              key_release;
    logic [pkeg_pkg::CODE_W-1:0]       key_code;
    logic                              drain_first;  // hold off until the output is drained
  } report_t;

  typedef struct {
    pkeg_pkg::event_kind_t        kind;
    logic [pkeg_pkg::COORD_W-1:0] pos_x;
    logic [pkeg_pkg::COORD_W-1:0] pos_y;
    logic [pkeg_pkg::BNUM_W-1:0]  bnum;
    logic [pkeg_pkg::BTN_W-1:0]   mask;
    logic [pkeg_pkg::CODE_W-1:0]  scan;
    logic                         last;
  } ptr_event_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic has_motion, has_key;
  logic signed [pkeg_pkg::REL_W-1:0] rel_x, rel_y;
  logic [pkeg_pkg::BTN_W-1:0] button_levels;
  logic key_release;
  logic [pkeg_pkg::CODE_W-1:0] key_code;
  logic cfg_valid, cfg_ready;
  logic [0:0] cfg_index;
  logic [pkeg_pkg::SIZE_W-1:0] cfg_data;
  logic out_valid, out_ready;
  logic [pkeg_pkg::KIND_W-1:0] event_kind;
  logic [pkeg_pkg::COORD_W-1:0] pos_x, pos_y;
  logic [pkeg_pkg::BNUM_W-1:0] button_number;
  logic [pkeg_pkg::BTN_W-1:0] button_mask;
  logic [pkeg_pkg::CODE_W-1:0] scan_out;
  logic last;

  pointer_and_key_event_generator_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .has_motion(has_motion), .has_key(has_key), .rel_x(rel_x), .rel_y(rel_y),
    .button_levels(button_levels), .key_release(key_release), .key_code(key_code),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .event_kind(event_kind), .pos_x(pos_x), .pos_y(pos_y),
    .button_number(button_number), .button_mask(button_mask),
    .scan_out(scan_out), .last(last)
  );

  report_t    pending_reports[$];
  ptr_event_t expected_events[$];
  report_t    cur_report;

  // shadow of the block's state
  int scr_w, scr_h, ptr_x, ptr_y;
  logic [pkeg_pkg::BTN_W-1:0] btn_state;

  int  cycle_count, mismatches, events_checked, reports_taken, size_writes;
  int  in_gap, out_stall;
  bit  in_idle_en, out_idle_en;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic int clamp_coord(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void add_event(ptr_event_t ev);
    expected_events = {expected_events, ev};
  endfunction

  function automatic void add_report(report_t r);
    pending_reports = {pending_reports, r};
  endfunction

  // Work out the events of one accepted report and update the shadow state.
  function automatic void predict_events(report_t r);
    ptr_event_t ev;
    logic [pkeg_pkg::BTN_W-1:0] lv;
    int nx, ny, n;
    ev.last = 1'b0;
    n = 0;
    if (r.has_motion) begin
      lv = r.button_levels & BTN_KEEP;
      nx = clamp_coord(ptr_x + int'(r.rel_x), scr_w - 1);
      ny = clamp_coord(ptr_y - int'(r.rel_y), scr_h - 1);  // positive rel_y is up
      ev.pos_x = pkeg_pkg::COORD_W'(nx);
      ev.pos_y = pkeg_pkg::COORD_W'(ny);
      ev.mask  = lv;
      ev.scan  = '0;
      if (nx != ptr_x || ny != ptr_y) begin
        ev.kind = pkeg_pkg::EV_MOVE;
        ev.bnum = '0;
        add_event(ev);
        n++;
      end
      ptr_x = nx;
      ptr_y = ny;
      for (int b = 0; b < pkeg_pkg::BTN_USED; b++) begin
        if (lv[b] != btn_state[b]) begin
          if (lv[b]) ev.kind = pkeg_pkg::EV_BTN_DOWN;
          else ev.kind = pkeg_pkg::EV_BTN_UP;
          ev.bnum = pkeg_pkg::BNUM_W'(b + 1);
          add_event(ev);
          n++;
        end
      end
      btn_state = lv;
    end
    if (r.has_key) begin
      if (r.key_release) ev.kind = pkeg_pkg::EV_KEY_UP;
      else ev.kind = pkeg_pkg::EV_KEY_DOWN;
      ev.pos_x = pkeg_pkg::COORD_W'(ptr_x);
      ev.pos_y = pkeg_pkg::COORD_W'(ptr_y);
      ev.bnum  = '0;
      ev.mask  = '0;
      ev.scan  = r.key_code;
      add_event(ev);
      n++;
    end
    if (n != 0) expected_events[expected_events.size()-1].last = 1'b1;
  endfunction

  function automatic report_t make_report(bit m, bit k, int rx, int ry, int btn,
                                          bit rel, int code, bit drain);
    report_t r;
    r.has_motion    = m;
    r.has_key       = k;
    r.rel_x         = pkeg_pkg::REL_W'(rx);
    r.rel_y         = pkeg_pkg::REL_W'(ry);
    r.button_levels = pkeg_pkg::BTN_W'(btn);
    r.key_release   = rel;
    r.key_code      = pkeg_pkg::CODE_W'(code);
    r.drain_first   = drain;
    return r;
  endfunction

  function automatic report_t rand_report();
    report_t r;
    int sel;
    sel = $urandom_range(0, 99);
    r.has_motion = (sel < 75);
    r.has_key    = (sel >= 55 && sel < 95);
    if ($urandom_range(0, 3) == 0) r.rel_x = pkeg_pkg::REL_W'($urandom);
    else r.rel_x = pkeg_pkg::REL_W'($urandom_range(0, 40) - 20);
    if ($urandom_range(0, 3) == 0) r.rel_y = pkeg_pkg::REL_W'($urandom);
    else r.rel_y = pkeg_pkg::REL_W'($urandom_range(0, 40) - 20);
    r.button_levels = pkeg_pkg::BTN_W'($urandom_range(0, 7));
    r.key_release   = 1'($urandom_range(0, 1));
    r.key_code      = pkeg_pkg::CODE_W'($urandom);
    r.drain_first   = ($urandom_range(0, 49) == 0);
    return r;
  endfunction

  // Report driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_events(cur_report);
        reports_taken++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_reports.size() != 0 &&
                     !(pending_reports[0].drain_first && expected_events.size() != 0)) begin
          cur_report = pending_reports[0];
          pending_reports.delete(0);
          in_valid      <= 1'b1;
          has_motion    <= cur_report.has_motion;
          has_key       <= cur_report.has_key;
          rel_x         <= cur_report.rel_x;
          rel_y         <= cur_report.rel_y;
          button_levels <= cur_report.button_levels;
          key_release   <= cur_report.key_release;
          key_code      <= cur_report.key_code;
          in_gap = in_idle_en ? pick_gap() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Event monitor
  always @(posedge clk) begin : event_monitor
    ptr_event_t want;
    if (rst) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_events.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: unexpected event kind=%0d x=%0d y=%0d btn=%0d",
                     cycle_count, event_kind, pos_x, pos_y, button_number);
        end else begin
          want = expected_events[0];
          expected_events.delete(0);
          events_checked++;
          if (event_kind !== want.kind || pos_x !== want.pos_x || pos_y !== want.pos_y ||
              button_number !== want.bnum || button_mask !== want.mask ||
              scan_out !== want.scan || last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("cycle %0d: expected kind=%0d x=%0d y=%0d btn=%0d mask=%b scan=%h last=%b",
                       cycle_count, want.kind, want.pos_x, want.pos_y, want.bnum,
                       want.mask, want.scan, want.last);
              $display("          actual   kind=%0d x=%0d y=%0d btn=%0d mask=%b scan=%h last=%b",
                       event_kind, pos_x, pos_y, button_number, button_mask,
                       scan_out, last);
            end
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (out_idle_en && $urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d events outstanding",
               cycle_count, expected_events.size());
      $display("FAIL pointer_and_key_event_generator_top");
      $finish;
    end
  end

  // Returns once no report is queued or in flight and all events have come out;
  // the settle time covers reports that produce no event.
  task automatic wait_idle();
    do begin
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_reports.size() != 0 || in_valid || expected_events.size() != 0);
  endtask

  task automatic write_size(input pkeg_pkg::reg_index_t idx, input int value);
    int s;
    wait_idle();
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= pkeg_pkg::SIZE_W'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    s = value & ((1 << pkeg_pkg::SIZE_W) - 1);
    if (s == 0) s = 1;
    if (s > 4096) s = 4096;
    if (idx == pkeg_pkg::REG_WIDTH) scr_w = s;
    else scr_h = s;
    ptr_x = scr_w / 2;
    ptr_y = scr_h / 2;
    size_writes++;
  endtask

  initial begin
    int w, h;
    rst = 1'b1;
    in_valid = 1'b0;
    has_motion = 1'b0;
    has_key = 1'b0;
    rel_x = '0;
    rel_y = '0;
    button_levels = '0;
    key_release = 1'b0;
    key_code = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_ready = 1'b0;
    in_idle_en = 1'b1;
    out_idle_en = 1'b1;
    scr_w = 640;
    scr_h = 480;
    ptr_x = 320;
    ptr_y = 240;
    btn_state = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, at the reset screen size
    add_report(make_report(0, 0, -256, 255, 7, 1, 255, 0)); // empty
    add_report(make_report(1, 0, 0, 0, 0, 0, 0, 0));        // no change
    add_report(make_report(1, 0, 255, 0, 0, 0, 0, 0));
    add_report(make_report(1, 0, 255, 0, 0, 0, 0, 0));      // clamp right
    add_report(make_report(1, 0, 1, 0, 0, 0, 0, 0));        // pinned
    add_report(make_report(1, 0, -256, 0, 0, 0, 0, 0));
    add_report(make_report(1, 0, -256, 0, 0, 0, 0, 0));
    add_report(make_report(1, 0, -256, 0, 0, 0, 0, 0));     // clamp left
    add_report(make_report(1, 0, -1, 0, 0, 0, 0, 0));
    add_report(make_report(1, 0, 0, 255, 0, 0, 0, 0));      // clamp top
    add_report(make_report(1, 0, 0, -256, 0, 0, 0, 0));
    add_report(make_report(1, 0, 0, -256, 0, 0, 0, 0));     // clamp bottom
    add_report(make_report(1, 1, 5, 5, 7, 0, 'h1c, 0));     // five events
    add_report(make_report(1, 1, 0, 0, 0, 1, 'hff, 0));
    add_report(make_report(0, 1, 3, 3, 7, 0, 'h00, 0));     // key only
    add_report(make_report(0, 1, -3, -3, 5, 1, 'h00, 0));
    add_report(make_report(1, 0, 0, 0, 5, 0, 0, 0));
    add_report(make_report(1, 0, 0, 0, 2, 0, 0, 0));        // all toggle
    add_report(make_report(1, 1, -3, 2, 2, 0, 'h5a, 1));
    add_report(make_report(1, 0, 255, -256, 0, 1, 'ha5, 0));
    add_report(make_report(0, 0, 0, 0, 0, 0, 0, 0));

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_size(pkeg_pkg::REG_WIDTH, 1);
          write_size(pkeg_pkg::REG_HEIGHT, 1);
        end
        1: begin
          write_size(pkeg_pkg::REG_WIDTH, 4096);
          write_size(pkeg_pkg::REG_HEIGHT, 4096);
        end
        2: begin
          write_size(pkeg_pkg::REG_HEIGHT, 0);
          write_size(pkeg_pkg::REG_WIDTH, 8191);
        end
        3: begin
          write_size(pkeg_pkg::REG_WIDTH, 0);
          write_size(pkeg_pkg::REG_HEIGHT, 5000);
        end
        4: begin
          w = $urandom_range(2, 300);
          h = $urandom_range(2, 300);
          write_size(pkeg_pkg::REG_HEIGHT, h);
          write_size(pkeg_pkg::REG_WIDTH, w);
        end
        default: begin
          w = $urandom_range(1, 4096);
          h = $urandom_range(1, 4096);
          write_size(pkeg_pkg::REG_WIDTH, w);
          write_size(pkeg_pkg::REG_HEIGHT, h);
        end
      endcase
      in_idle_en  = (ph % 3 != 0);
      out_idle_en = (ph % 3 != 1);
      @(negedge clk);
      for (int i = 0; i < REPORTS_PER_PHASE; i++) add_report(rand_report());
    end

    wait_idle();
    $display("%0d reports in, %0d events checked over %0d screen size writes",
             reports_taken, events_checked, size_writes);
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("PASS pointer_and_key_event_generator_top");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("FAIL pointer_and_key_event_generator_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/pkeg_pkg.sv
design/pkeg_front.sv
design/pkeg_queue.sv
design/pkeg_back.sv
design/pointer_and_key_event_generator_top.sv
verif/pointer_and_key_event_generator_top_tb.sv
